// ----- design/mbps_pkg.sv -----
// ============================================================================
// mbps_pkg: shared definitions for the masked byte pattern scanner
// Widths, sizes, register indexes and the window type used by the scan core.
// ============================================================================
package mbps_pkg;

  // Window depth and the largest usable pattern length.
  localparam int PATTERN_MAX = 16;
  localparam int CFG_BYTES   = 16;
  localparam int EFF_MAX     = (PATTERN_MAX < CFG_BYTES) ? PATTERN_MAX : CFG_BYTES;

  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 48;
  localparam int OFFSET_W = 32;
  localparam int MASK_W   = 16;
  localparam int LEN_W    = 5;
  localparam int CNT_W    = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = ((BYTE_W + ADDR_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((ADDR_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_RESULT_OFFSET  = 3'd4
  } cfg_reg_e;

  typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_t;

endpackage

// ----- design/masked_byte_pattern_scan_core.sv -----
// ============================================================================
// masked_byte_pattern_scan_core: wildcard byte pattern search over a stream
// Slides a window over incoming memory bytes and reports the first masked
// pattern match of each scan, or a no-match beat when the scan ends.
// ============================================================================
// Usage:
//   The slave stream carries one memory byte per beat with its address in
//   tdata; tuser flags the first byte of a new readable region and tlast
//   marks the last byte of the scan. Each scan yields at most one beat on
//   the master stream: tuser=1 with the match start address plus the
//   configured offset, or tuser=0 with a zero address when the scan ends
//   without a match. Bytes after a match up to tlast produce nothing.
//   One byte is accepted per cycle while tready is high. A result reaches
//   the master stream by way of the input register: its byte is held there
//   first, then the window update and the 16-byte parallel compare load
//   the output register once that register is free.
//   When the master side stalls, the input register holds one more byte
//   and tready drops only while both registers are full.
//   Reset empties the pipeline and the window, and restores the pattern
//   registers to an all-zero 16-byte pattern with every byte cared for and
//   a zero offset. The configuration channel is always ready; write it only
//   while the stream is idle.
// ============================================================================
module masked_byte_pattern_scan_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] data_byte, [55:8] byte_address
  input  logic [mbps_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // [0] region_start
  input  logic                             s_axis_tuser,
  // scan_end
  input  logic                             s_axis_tlast,

  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [47:0] match_address
  output logic [mbps_pkg::M_DATA_W-1:0]    m_axis_tdata,
  // [0] found
  output logic                             m_axis_tuser
);

  // Configuration registers.
  logic [2*mbps_pkg::CFG_DATA_W-1:0]  pattern_q;
  logic [mbps_pkg::MASK_W-1:0]        care_mask_q;
  logic [mbps_pkg::LEN_W-1:0]         pattern_length_q;
  logic [mbps_pkg::OFFSET_W-1:0]      result_offset_q;

  // Input register.
  logic                               in_valid_q;
  logic [mbps_pkg::BYTE_W-1:0]        in_byte_q;
  logic [mbps_pkg::ADDR_W-1:0]        in_addr_q;
  logic                               in_rstart_q;
  logic                               in_end_q;

  // Scan state.
  mbps_pkg::window_t                  window_q, window_d;
  logic [mbps_pkg::CNT_W-1:0]         count_q, count_d;
  logic                               match_done_q, match_done_d;

  // Output register.
  logic                               out_valid_q;
  logic                               out_found_q;
  logic [mbps_pkg::ADDR_W-1:0]        out_addr_q;

  logic                               proc;
  logic                               hit;
  logic                               out_load;
  logic [mbps_pkg::CNT_W-1:0]         eff_len;
  logic [mbps_pkg::CNT_W-1:0]         shift_count;
  logic [mbps_pkg::ADDR_W-1:0]        match_addr;

  assign cfg_ready_o   = 1'b1;
  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q        <= '0;
      care_mask_q      <= '1;
      pattern_length_q <= mbps_pkg::LEN_W'(16);
      result_offset_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mbps_pkg::REG_PATTERN_LOW:
          pattern_q[mbps_pkg::CFG_DATA_W-1:0] <= cfg_data_i;
        mbps_pkg::REG_PATTERN_HIGH:
          pattern_q[2*mbps_pkg::CFG_DATA_W-1:mbps_pkg::CFG_DATA_W] <= cfg_data_i;
        mbps_pkg::REG_CARE_MASK:
          care_mask_q <= cfg_data_i[mbps_pkg::MASK_W-1:0];
        mbps_pkg::REG_PATTERN_LENGTH:
          pattern_length_q <= cfg_data_i[mbps_pkg::LEN_W-1:0];
        mbps_pkg::REG_RESULT_OFFSET:
          result_offset_q <= cfg_data_i[mbps_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q   <= s_axis_tdata[mbps_pkg::BYTE_W-1:0];
      in_addr_q   <= s_axis_tdata[mbps_pkg::BYTE_W +: mbps_pkg::ADDR_W];
      in_rstart_q <= s_axis_tuser;
      in_end_q    <= s_axis_tlast;
    end
  end

  // Length zero behaves as one, lengths past the window as the window depth.
  always_comb begin
    if (pattern_length_q == '0) begin
      eff_len = mbps_pkg::CNT_W'(1);
    end else if (32'(pattern_length_q) > mbps_pkg::EFF_MAX) begin
      eff_len = mbps_pkg::CNT_W'(mbps_pkg::EFF_MAX);
    end else begin
      eff_len = mbps_pkg::CNT_W'(pattern_length_q);
    end
  end

  // Window shift, region restart and the parallel masked compare.
  always_comb begin
    logic [mbps_pkg::CNT_W-1:0] widx;
    logic [mbps_pkg::BYTE_W-1:0] pbyte;

    window_d[0] = in_byte_q;
    for (int i = 1; i < mbps_pkg::PATTERN_MAX; i++) begin
      window_d[i] = in_rstart_q ? '0 : window_q[i-1];
    end

    if (in_rstart_q) begin
      shift_count = mbps_pkg::CNT_W'(1);
    end else if (32'(count_q) < mbps_pkg::PATTERN_MAX) begin
      shift_count = count_q + mbps_pkg::CNT_W'(1);
    end else begin
      shift_count = count_q;
    end

    hit = (shift_count >= eff_len);
    for (int i = 0; i < mbps_pkg::EFF_MAX; i++) begin
      // Pattern byte i lines up with the window slot n-1-i (newest is slot 0).
      widx  = eff_len - mbps_pkg::CNT_W'(1) - mbps_pkg::CNT_W'(i);
      pbyte = pattern_q[i*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
      if ((mbps_pkg::CNT_W'(i) < eff_len) && care_mask_q[i] &&
          (pbyte != window_d[widx[mbps_pkg::IDX_W-1:0]])) begin
        hit = 1'b0;
      end
    end

    match_addr = in_addr_q - mbps_pkg::ADDR_W'(eff_len - mbps_pkg::CNT_W'(1))
               + {{(mbps_pkg::ADDR_W-mbps_pkg::OFFSET_W){result_offset_q[mbps_pkg::OFFSET_W-1]}},
                  result_offset_q};
  end

  assign out_load = proc && !match_done_q && (hit || in_end_q);

  always_comb begin
    match_done_d = match_done_q;
    count_d      = count_q;
    if (!match_done_q) begin
      count_d = shift_count;
      if (hit) begin
        match_done_d = 1'b1;
      end
    end
    // The last byte of a scan always leaves a fresh, empty window behind.
    if (in_end_q) begin
      match_done_d = 1'b0;
      count_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      match_done_q <= 1'b0;
    end else if (proc) begin
      count_q      <= count_d;
      match_done_q <= match_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && !match_done_q) begin
      window_q <= window_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= hit;
      out_addr_q  <= hit ? match_addr : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = mbps_pkg::M_DATA_W'(out_addr_q);

  // A no-match beat always carries a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("no-match beat with nonzero address");

  // The window fill count never passes the window depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= mbps_pkg::PATTERN_MAX)
    else $error("window count overflow");

  // A match inside a scan suppresses further results until the scan ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && hit && !in_end_q |=> match_done_q)
    else $error("match not latched");

  // With the output register empty, the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // A scan end always resets the window state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_end_q |=> count_q == '0 && !match_done_q)
    else $error("scan end did not clear state");

endmodule

// ----- tb/masked_byte_pattern_scan_core_tb.sv -----
// ============================================================================
// masked_byte_pattern_scan_core_tb: self-checking bench for the pattern scanner
// Streams memory bytes through the scanner and checks every result beat
// against a cycle-free model of the masked window compare. A directed opening
// covers reset values, address wrap and length limits. Random scans follow,
// most of them carrying planted or nearly planted patterns, under several
// register settings with random gaps and stalls on both streams.
// ============================================================================
module masked_byte_pattern_scan_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 115;

  typedef struct {
    bit                          found;
    logic [mbps_pkg::ADDR_W-1:0] addr;
  } scan_result_t;

  // Tracks the scan state and holds the result beats still owed by the block.
  class match_tracker;
    logic [63:0]                 pattern_low;
    logic [63:0]                 pattern_high;
    logic [mbps_pkg::MASK_W-1:0] care_mask;
    logic [mbps_pkg::LEN_W-1:0]  pattern_length;
    logic [31:0]                 result_offset;
    logic [7:0]                  window [mbps_pkg::PATTERN_MAX];
    int unsigned                 held;
    bit                          matched;
    scan_result_t                pending_matches[$];
    int unsigned                 failures;

    function new();
      pattern_low    = '0;
      pattern_high   = '0;
      care_mask      = '1;
      pattern_length = mbps_pkg::LEN_W'(16);
      result_offset  = '0;
      matched        = 1'b0;
      failures       = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (window[i]) window[i] = 8'h00;
      held = 0;
    endfunction

    function int unsigned eff_len();
      int unsigned n;
      n = pattern_length;
      if (n == 0) n = 1;
      if (n > mbps_pkg::EFF_MAX) n = mbps_pkg::EFF_MAX;
      return n;
    endfunction

    function logic [7:0] pattern_byte(int unsigned i);
      logic [127:0] pat;
      pat = {pattern_high, pattern_low};
      return pat[8*i +: 8];
    endfunction

    function void write_reg(mbps_pkg::cfg_reg_e idx,
                            logic [mbps_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        mbps_pkg::REG_PATTERN_LOW:    pattern_low    = value;
        mbps_pkg::REG_PATTERN_HIGH:   pattern_high   = value;
        mbps_pkg::REG_CARE_MASK:      care_mask      = value[mbps_pkg::MASK_W-1:0];
        mbps_pkg::REG_PATTERN_LENGTH: pattern_length = value[mbps_pkg::LEN_W-1:0];
        mbps_pkg::REG_RESULT_OFFSET:  result_offset  = value[31:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] data, logic [mbps_pkg::ADDR_W-1:0] addr,
                            bit region_first, bit scan_last);
      int unsigned                 n;
      bit                          hit;
      logic [mbps_pkg::ADDR_W-1:0] start;
      logic [mbps_pkg::ADDR_W-1:0] offset;
      if (!matched) begin
        n = eff_len();
        if (region_first) clear_window();
        for (int i = mbps_pkg::PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = data;
        if (held < mbps_pkg::PATTERN_MAX) held++;
        // The oldest byte of the window slice lines up with pattern byte 0.
        hit = (held >= n);
        for (int i = 0; i < n; i++) begin
          if (care_mask[i] && pattern_byte(i) != window[n-1-i]) hit = 1'b0;
        end
        if (hit) begin
          start  = addr - mbps_pkg::ADDR_W'(n - 1);
          offset = {{(mbps_pkg::ADDR_W-32){result_offset[31]}}, result_offset};
          pending_matches.push_back('{1'b1, start + offset});
          matched = 1'b1;
        end else if (scan_last) begin
          pending_matches.push_back('{1'b0, '0});
        end
      end
      if (scan_last) begin
        clear_window();
        matched = 1'b0;
      end
    endfunction

    function void check_match(bit found, logic [mbps_pkg::ADDR_W-1:0] addr);
      scan_result_t exp_r;
      if (pending_matches.size() == 0) begin
        $display("%0t: result beat with none expected: found=%0b address=%h",
                 $time, found, addr);
        failures++;
      end else begin
        exp_r = pending_matches.pop_front();
        if (found !== exp_r.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, exp_r.found, found);
          failures++;
        end
        if (addr !== exp_r.addr) begin
          $display("%0t: match_address mismatch: expected %h, actual %h",
                   $time, exp_r.addr, addr);
          failures++;
        end
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [mbps_pkg::S_DATA_W-1:0]   s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            s_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [mbps_pkg::M_DATA_W-1:0]   m_axis_tdata;
  logic                            m_axis_tuser;

  match_tracker tracker = new();
  bit           idle_on;
  bit           hold_req;
  int unsigned  bytes_sent;
  int unsigned  quiet_cycles;

  masked_byte_pattern_scan_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Input beats are noted before result beats, since a result always trails its byte.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        tracker.write_reg(mbps_pkg::cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_byte(s_axis_tdata[mbps_pkg::BYTE_W-1:0],
                          s_axis_tdata[mbps_pkg::BYTE_W +: mbps_pkg::ADDR_W],
                          s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_match(m_axis_tuser, m_axis_tdata[mbps_pkg::ADDR_W-1:0]);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = 150;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  task automatic drive_byte(logic [7:0] data, logic [mbps_pkg::ADDR_W-1:0] addr,
                            bit rs, bit last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {addr, data};
    s_axis_tuser  <= rs;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic write_reg(mbps_pkg::cfg_reg_e idx, logic [mbps_pkg::CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Registers change only once the stream has drained.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_matches.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One scan: random bytes, usually with the pattern planted somewhere in it.
  task automatic run_scan();
    int unsigned                 len_n;
    int unsigned                 nbytes;
    int unsigned                 pos;
    int unsigned                 miss_at;
    bit                          plant;
    bit                          near_miss;
    bit                          noise;
    bit                          rs;
    bit                          last;
    logic [mbps_pkg::ADDR_W-1:0] addr;
    logic [7:0]                  b;
    len_n     = tracker.eff_len();
    noise     = ($urandom_range(0, 9) == 0);
    nbytes    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40)
                                            : $urandom_range(1, 2 * len_n + 4);
    plant     = ($urandom_range(0, 3) != 0) && (nbytes >= len_n);
    pos       = plant ? $urandom_range(0, nbytes - len_n) : 0;
    near_miss = ($urandom_range(0, 4) == 0);
    miss_at   = $urandom_range(0, len_n - 1);
    addr      = ($urandom_range(0, 7) == 0)
              ? mbps_pkg::ADDR_W'(48'hFFFF_FFFF_FFF0 + $urandom_range(0, 15))
              : mbps_pkg::ADDR_W'(rand64());
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom_range(0, 255));
      if (plant && i >= pos && i < pos + len_n && tracker.care_mask[i-pos]) begin
        b = tracker.pattern_byte(i - pos);
        if (near_miss && (i - pos) == miss_at) b = b ^ (8'h01 << $urandom_range(0, 7));
      end
      rs   = (i == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 11) == 0);
      last = (i == nbytes - 1) || (noise && $urandom_range(0, 7) == 0);
      // A new region usually sits somewhere else in the address space.
      if (rs && i != 0) addr = mbps_pkg::ADDR_W'(rand64());
      drive_byte(b, addr, rs, last);
      addr = addr + mbps_pkg::ADDR_W'(1);
    end
  endtask

  initial begin
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [63:0] mask_d;
    logic [63:0] len_d;
    logic [63:0] off_d;
    int unsigned phase_end;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = mbps_pkg::REG_PATTERN_LOW;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    idle_on       = 1'b0;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset pattern: sixteen zero bytes match on the scan's last byte, and
    // the start address wraps below zero.
    for (int i = 0; i < 16; i++)
      drive_byte(8'h00, (i == 15) ? mbps_pkg::ADDR_W'(3)
                                  : mbps_pkg::ADDR_W'(48'hFFFF_FFFF_FFF1 + i),
                 i == 0, i == 15);
    wait_idle();

    // Length zero acts as one; most negative offset; junk in unused data bits.
    write_reg(mbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
    write_reg(mbps_pkg::REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(mbps_pkg::REG_CARE_MASK, 64'hABCD_0000_0000_0001);
    write_reg(mbps_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
    write_reg(mbps_pkg::REG_RESULT_OFFSET, 64'h1234_5678_8000_0000);
    cfg_valid_i <= 1'b0;
    drive_byte(8'h00, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
    drive_byte(8'hFF, 48'h0000_1234_5678, 1'b0, 1'b0);
    drive_byte(8'hFF, 48'h0000_1234_5679, 1'b0, 1'b0);  // ignored after the match
    drive_byte(8'h12, 48'h0000_1234_567A, 1'b0, 1'b1);  // closes the scan silently
    drive_byte(8'h00, 48'h8000_0000_0000, 1'b1, 1'b1);  // no match in a one-byte scan
    drive_byte(8'hFF, 48'h0000_0000_0000, 1'b1, 1'b1);  // match on a one-byte scan

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      pat_lo = rand64();
      pat_hi = rand64();
      mask_d = rand64();
      len_d  = rand64();
      off_d  = rand64();
      case (ph)
        0: begin
          mask_d[15:0] = 16'hFFFF;
          len_d[4:0]   = 5'($urandom_range(1, 16));
          idle_on      = 1'b1;
        end
        1: begin
          len_d[4:0]   = 5'd16;
          off_d[31:0]  = 32'h7FFF_FFFF;
          idle_on      = 1'b1;
          hold_req     = 1'b1;
        end
        2: begin
          len_d[4:0]   = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
          idle_on      = 1'b0;
        end
        3: begin
          mask_d[15:0] = 16'h0000;
          len_d[4:0]   = 5'($urandom_range(1, 16));
          idle_on      = 1'b1;
        end
        4: begin
          len_d[4:0]   = 5'($urandom_range(1, 16));
          idle_on      = 1'b1;
        end
        default: begin
          mask_d[15:0] = 16'hFFFF;
          len_d[4:0]   = 5'd1;
          off_d[31:0]  = 32'h8000_0000;
          idle_on      = 1'b0;
        end
      endcase
      write_reg(mbps_pkg::REG_PATTERN_LOW, pat_lo);
      write_reg(mbps_pkg::REG_PATTERN_HIGH, pat_hi);
      write_reg(mbps_pkg::REG_CARE_MASK, mask_d);
      write_reg(mbps_pkg::REG_PATTERN_LENGTH, len_d);
      write_reg(mbps_pkg::REG_RESULT_OFFSET, off_d);
      cfg_valid_i <= 1'b0;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) run_scan();
    end

    wait_idle();
    repeat (4) @(negedge clk_i);
    if (tracker.failures == 0 && tracker.pending_matches.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
